[hdl/range_gate_polar_to_cartesian_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the range gate polar-to-cartesian block
// Clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef RANGE_GATE_POLAR_TO_CARTESIAN_ASSERT_SVH
`define RANGE_GATE_POLAR_TO_CARTESIAN_ASSERT_SVH

// same-cycle implication
`define RGPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgpc assertion failed: same-cycle implication");

// next-cycle implication
`define RGPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgpc assertion failed: next-cycle implication");

`endif

[hdl/rgpc_pkg.sv]
// ----------------------------------------------------------------------------
// rgpc_pkg
// Shared types, widths and fixed-point constants of the range gate
// polar-to-cartesian block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgpc_pkg;

  // field widths
  localparam int RANGE_W = 16;
  localparam int STEP_W  = 12;
  localparam int ANGLE_W = 16;
  localparam int POS_W   = 17;
  localparam int CFG_W   = 16;

  // queue between front and back (power of two)
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // register reset values
  localparam logic [RANGE_W-1:0] MIN_RANGE_RST      = 16'd20;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST      = 16'd5600;
  localparam logic [STEP_W-1:0]  FRONT_STEP_RST     = 12'd384;
  localparam logic [ANGLE_W-1:0] ANGLE_PER_STEP_RST = 16'd64;

  // Q30 one and 2*pi in Q32
  localparam logic [30:0] ONE        = 31'h4000_0000;
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;

  // polynomial steps: floor(v/k) = (v*ceil(2^s/k)) >> s, s = 30 + clog2(k)
  localparam int SIN_STEPS = 4;
  localparam int COS_STEPS = 5;

  localparam logic [30:0] SIN_RECIP [SIN_STEPS] = '{
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int SIN_SHIFT [SIN_STEPS] = '{37, 36, 35, 33};

  localparam logic [30:0] COS_RECIP [COS_STEPS] = '{
    31'(((64'd1 << 37) + 64'd89) / 64'd90),
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12),
    31'(((64'd1 << 31) + 64'd1) / 64'd2)
  };
  localparam int COS_SHIFT [COS_STEPS] = '{37, 36, 35, 34, 31};

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_RANGE      = 2'd0,
    CFG_MAX_RANGE      = 2'd1,
    CFG_FRONT_STEP     = 2'd2,
    CFG_ANGLE_PER_STEP = 2'd3
  } cfg_reg_t;

  // nearest quadrant of the beam angle
  typedef enum logic [1:0] {
    QUAD_E = 2'd0,
    QUAD_N = 2'd1,
    QUAD_W = 2'd2,
    QUAD_S = 2'd3
  } quad_t;

  // one gated sample waiting for conversion
  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [ANGLE_W-1:0] angle;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // per-sample data carried alongside the trig lanes
  typedef struct packed {
    logic [RANGE_W-1:0] range;
    quad_t              quad;
    logic               rneg;
  } side_t;

endpackage

`default_nettype wire

[hdl/rgpc_front.sv]
// ----------------------------------------------------------------------------
// rgpc_front
// Configuration registers, range gate and beam angle computation. Passing
// samples are pushed into the queue; gated samples are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [rgpc_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rgpc_pkg::RANGE_W-1:0] in_range_mm,
  input  wire logic [rgpc_pkg::STEP_W-1:0]  in_step_index,
  input  wire rgpc_pkg::q_stat_t            q_stat,
  output logic                              push,
  output rgpc_pkg::item_t                   push_item
);

  logic [rgpc_pkg::RANGE_W-1:0] min_range_r;
  logic [rgpc_pkg::RANGE_W-1:0] max_range_r;
  logic [rgpc_pkg::STEP_W-1:0]  front_step_r;
  logic [rgpc_pkg::ANGLE_W-1:0] angle_per_step_r;

  logic                         in_pass;
  logic [rgpc_pkg::ANGLE_W-1:0] step_diff;
  logic [2*rgpc_pkg::ANGLE_W-1:0] angle_prod;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r      <= rgpc_pkg::MIN_RANGE_RST;
      max_range_r      <= rgpc_pkg::MAX_RANGE_RST;
      front_step_r     <= rgpc_pkg::FRONT_STEP_RST;
      angle_per_step_r <= rgpc_pkg::ANGLE_PER_STEP_RST;
    end else if (cfg_we) begin
      unique case (rgpc_pkg::cfg_reg_t'(cfg_index))
        rgpc_pkg::CFG_MIN_RANGE:      min_range_r      <= cfg_data;
        rgpc_pkg::CFG_MAX_RANGE:      max_range_r      <= cfg_data;
        rgpc_pkg::CFG_FRONT_STEP:     front_step_r     <= cfg_data[rgpc_pkg::STEP_W-1:0];
        rgpc_pkg::CFG_ANGLE_PER_STEP: angle_per_step_r <= cfg_data;
        default:                      ;
      endcase
    end
  end

  // keep ranges strictly inside the gate
  assign in_pass = (in_range_mm > min_range_r) && (in_range_mm < max_range_r);

  // beam angle, wrapping in 1/65536 turn
  assign step_diff  = rgpc_pkg::ANGLE_W'(in_step_index) - rgpc_pkg::ANGLE_W'(front_step_r);
  assign angle_prod = (2*rgpc_pkg::ANGLE_W)'(step_diff) *
                      (2*rgpc_pkg::ANGLE_W)'(angle_per_step_r);

  // accept while the queue has room, push only passing beats
  assign in_ready        = !q_stat.full;
  assign push            = in_valid && in_ready && in_pass;
  assign push_item.range = in_range_mm;
  assign push_item.angle = angle_prod[rgpc_pkg::ANGLE_W-1:0];

endmodule

`default_nettype wire

[hdl/rgpc_queue.sv]
// ----------------------------------------------------------------------------
// rgpc_queue
// Short FIFO that decouples the gate front from the trig pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rgpc_pkg::item_t push_item,
  input  wire logic            pop,
  output rgpc_pkg::item_t      pop_item,
  output rgpc_pkg::q_stat_t    q_stat
);

  rgpc_pkg::item_t                mem_r [rgpc_pkg::Q_DEPTH];
  logic [rgpc_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [rgpc_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [rgpc_pkg::Q_PTR_W:0]     count_r;
  logic [rgpc_pkg::Q_PTR_W:0]     count_nxt;

  // store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // update fill level
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + (rgpc_pkg::Q_PTR_W+1)'(1);
      2'b01:   count_nxt = count_r - (rgpc_pkg::Q_PTR_W+1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rgpc_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rgpc_pkg::Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (rgpc_pkg::Q_PTR_W+1)'(rgpc_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

`default_nettype wire

[hdl/rgpc_trig.sv]
// ----------------------------------------------------------------------------
// rgpc_trig
// Thirteen-stage pipeline: quadrant reduction, fixed-point sine and cosine
// polynomials, range scaling and sign. The whole pipe holds while the
// output beat is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_gate_polar_to_cartesian_assert.svh"

module rgpc_trig (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rgpc_pkg::q_stat_t          q_stat,
  input  wire rgpc_pkg::item_t            pop_item,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [rgpc_pkg::POS_W-1:0] out_pos_x,
  output logic signed [rgpc_pkg::POS_W-1:0] out_pos_y
);

  localparam int LAST = 13;

  logic [LAST:1]   vld_r;
  logic            adv;

  // stage 1 reduction
  logic [15:0]     a_off;
  logic [13:0]     rr;
  logic            rneg;
  logic [13:0]     ar;
  logic [48:0]     u_full;
  logic [59:0]     u_sq;

  // carried values
  logic [29:0]     u_r  [1:9];
  logic [29:0]     u2_r [2:9];
  rgpc_pkg::side_t side_r [1:11];

  // polynomial lanes
  logic [30:0]     s_t_r    [rgpc_pkg::SIN_STEPS];
  logic [29:0]     s_prod_r [1:rgpc_pkg::SIN_STEPS-1];
  logic [30:0]     c_t_r    [rgpc_pkg::COS_STEPS];
  logic [29:0]     c_prod_r [1:rgpc_pkg::COS_STEPS-1];

  // sine magnitude and alignment
  logic [60:0]     s_fin;
  logic [29:0]     smag_r;
  logic [29:0]     smag_d_r;

  // quadrant select and scaling
  logic [30:0]     cos_mag;
  logic [30:0]     sin_mag;
  logic            cos_neg;
  logic            sin_neg;
  logic [46:0]     x_full;
  logic [46:0]     y_full;
  logic [rgpc_pkg::POS_W-1:0] x_mag_r;
  logic [rgpc_pkg::POS_W-1:0] y_mag_r;
  logic            x_neg_r;
  logic            y_neg_r;
  logic [rgpc_pkg::POS_W-1:0] out_x_r;
  logic [rgpc_pkg::POS_W-1:0] out_y_r;

  // advance the pipe unless the output beat is stalled
  assign adv = !vld_r[LAST] || out_ready;
  assign pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:1], pop};
    end
  end

  // reduce to nearest quadrant and signed residue, scale to radians
  assign a_off  = pop_item.angle + 16'd8192;
  assign rr     = a_off[13:0];
  assign rneg   = !rr[13];
  assign ar     = rr[13] ? {1'b0, rr[12:0]} : (14'd8192 - rr);
  assign u_full = 49'(ar) * 49'(rgpc_pkg::TWO_PI_Q32);
  assign u_sq   = 60'(u_r[1]) * 60'(u_r[1]);

  // load stage 1, square at stage 2, shift carried values
  always_ff @(posedge clk) begin
    if (adv) begin
      u_r[1]          <= u_full[47:18];
      side_r[1].range <= pop_item.range;
      side_r[1].quad  <= rgpc_pkg::quad_t'(a_off[15:14]);
      side_r[1].rneg  <= rneg;
      u2_r[2]         <= u_sq[59:30];
      for (int p = 2; p <= 9; p++) begin
        u_r[p] <= u_r[p-1];
      end
      for (int p = 3; p <= 9; p++) begin
        u2_r[p] <= u2_r[p-1];
      end
      for (int p = 2; p <= 11; p++) begin
        side_r[p] <= side_r[p-1];
      end
    end
  end

  // sine polynomial: t = ONE - ((u2*t) >> 30) / k, first step has t = ONE
  for (genvar j = 0; j < rgpc_pkg::SIN_STEPS; j++) begin : g_sin
    logic [29:0] div_in;
    logic [60:0] div_prod;
    if (j == 0) begin : g_first
      assign div_in = u2_r[2];
    end else begin : g_mul
      logic [60:0] mul;
      assign mul = 61'(u2_r[2*j+1]) * 61'(s_t_r[j-1]);
      always_ff @(posedge clk) begin
        if (adv) begin
          s_prod_r[j] <= mul[59:30];
        end
      end
      assign div_in = s_prod_r[j];
    end
    assign div_prod = 61'(div_in) * 61'(rgpc_pkg::SIN_RECIP[j]);
    always_ff @(posedge clk) begin
      if (adv) begin
        s_t_r[j] <= rgpc_pkg::ONE - 31'(div_prod >> rgpc_pkg::SIN_SHIFT[j]);
      end
    end
  end

  // cosine polynomial, same step form
  for (genvar j = 0; j < rgpc_pkg::COS_STEPS; j++) begin : g_cos
    logic [29:0] div_in;
    logic [60:0] div_prod;
    if (j == 0) begin : g_first
      assign div_in = u2_r[2];
    end else begin : g_mul
      logic [60:0] mul;
      assign mul = 61'(u2_r[2*j+1]) * 61'(c_t_r[j-1]);
      always_ff @(posedge clk) begin
        if (adv) begin
          c_prod_r[j] <= mul[59:30];
        end
      end
      assign div_in = c_prod_r[j];
    end
    assign div_prod = 61'(div_in) * 61'(rgpc_pkg::COS_RECIP[j]);
    always_ff @(posedge clk) begin
      if (adv) begin
        c_t_r[j] <= rgpc_pkg::ONE - 31'(div_prod >> rgpc_pkg::COS_SHIFT[j]);
      end
    end
  end

  // sine magnitude at stage 10, delay one stage to meet cosine
  assign s_fin = 61'(u_r[9]) * 61'(s_t_r[rgpc_pkg::SIN_STEPS-1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      smag_r   <= s_fin[59:30];
      smag_d_r <= smag_r;
    end
  end

  // map magnitudes and signs by quadrant
  always_comb begin
    unique case (side_r[11].quad)
      rgpc_pkg::QUAD_E: begin
        cos_mag = c_t_r[rgpc_pkg::COS_STEPS-1];
        cos_neg = 1'b0;
        sin_mag = {1'b0, smag_d_r};
        sin_neg = side_r[11].rneg;
      end
      rgpc_pkg::QUAD_N: begin
        cos_mag = {1'b0, smag_d_r};
        cos_neg = !side_r[11].rneg;
        sin_mag = c_t_r[rgpc_pkg::COS_STEPS-1];
        sin_neg = 1'b0;
      end
      rgpc_pkg::QUAD_W: begin
        cos_mag = c_t_r[rgpc_pkg::COS_STEPS-1];
        cos_neg = 1'b1;
        sin_mag = {1'b0, smag_d_r};
        sin_neg = !side_r[11].rneg;
      end
      rgpc_pkg::QUAD_S: begin
        cos_mag = {1'b0, smag_d_r};
        cos_neg = side_r[11].rneg;
        sin_mag = c_t_r[rgpc_pkg::COS_STEPS-1];
        sin_neg = 1'b1;
      end
      default: begin
        cos_mag = '0;
        cos_neg = 1'b0;
        sin_mag = '0;
        sin_neg = 1'b0;
      end
    endcase
  end

  // scale by range, truncate magnitude
  assign x_full = 47'(side_r[11].range) * 47'(cos_mag);
  assign y_full = 47'(side_r[11].range) * 47'(sin_mag);

  always_ff @(posedge clk) begin
    if (adv) begin
      x_mag_r <= x_full[46:30];
      y_mag_r <= y_full[46:30];
      x_neg_r <= cos_neg;
      y_neg_r <= sin_neg;
      out_x_r <= x_neg_r ? (rgpc_pkg::POS_W'(0) - x_mag_r) : x_mag_r;
      out_y_r <= y_neg_r ? (rgpc_pkg::POS_W'(0) - y_mag_r) : y_mag_r;
    end
  end

  assign out_valid = vld_r[LAST];
  assign out_pos_x = signed'(out_x_r);
  assign out_pos_y = signed'(out_y_r);

  // pipe freezes under a stalled output beat
  `RGPC_ASSERT_NEXT(a_stall_hold, clk, rst_n, vld_r[LAST] && !out_ready, vld_r == $past(vld_r))
  // a popped item always enters stage 1
  `RGPC_ASSERT_NEXT(a_pop_enters, clk, rst_n, pop, vld_r[1])
  // cosine magnitude of a valid stage-11 sample never exceeds one
  `RGPC_ASSERT_IMPLIES(a_cos_bound, clk, rst_n, vld_r[11], c_t_r[rgpc_pkg::COS_STEPS-1] <= rgpc_pkg::ONE)

endmodule

`default_nettype wire

[hdl/range_gate_polar_to_cartesian.sv]
// ----------------------------------------------------------------------------
// range_gate_polar_to_cartesian
// Converts laser range samples (range_mm, step_index) to x/y millimetres.
// Input beats come in on in_valid/in_ready; samples whose range is not
// strictly between min_range and max_range are dropped without a result.
// Results leave on out_valid/out_ready as signed pos_x/pos_y, in order.
// Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block does not enforce it.
// Throughput: one beat per cycle while out_ready is high, set by the
// fully pipelined trig unit. Queued samples enter 13 pipeline stages
// (reduction, square, sine and cosine polynomial steps at two stages
// each after the first, range scaling, sign).
// A 4-entry queue sits between gate and pipeline; when out_ready is low
// the pipeline holds and the queue fills, and in_ready drops only once
// the queue is full. Reset clears the queue and pipeline and loads the
// register defaults (20, 5600, 384, 64).
// ----------------------------------------------------------------------------
`default_nettype none

module range_gate_polar_to_cartesian (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [rgpc_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rgpc_pkg::RANGE_W-1:0] in_range_mm,
  input  wire logic [rgpc_pkg::STEP_W-1:0]  in_step_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [rgpc_pkg::POS_W-1:0] out_pos_x,
  output logic signed [rgpc_pkg::POS_W-1:0] out_pos_y
);

  rgpc_pkg::q_stat_t q_stat;
  rgpc_pkg::item_t   push_item;
  rgpc_pkg::item_t   pop_item;
  logic              push;
  logic              pop;

  // gate and angle
  rgpc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_range_mm   (in_range_mm),
    .in_step_index (in_step_index),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  rgpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // trig pipeline
  rgpc_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y)
  );

endmodule

`default_nettype wire
